@@ src/knn_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the k-nearest-neighbor position lookup.
// No dependencies; used by every module of the block but knn_ram.
package knn_pkg;

    localparam int COORD_W     = 24;
    localparam int MAX_POINTS  = 65536;
    localparam int PT_AW       = 16;
    localparam int CNT_W       = 17;
    localparam int MAX_NB      = 16;
    localparam int NB_AW       = 4;
    localparam int NB_CW       = 5;
    localparam int MAG_W       = 24;
    localparam int SQ_W        = 48;
    localparam int DIST_W      = 50;
    localparam logic [DIST_W-1:0] EPS_DIST = DIST_W'(43);
    localparam int WEIGHT_BITS = 24;
    localparam int W_W         = 25;
    localparam int REM_W       = 52;
    localparam int HALF_W      = 17;
    localparam int PROD_W      = 42;
    localparam int ACC_W       = 48;
    localparam int SW_W        = 29;
    localparam int DIV_NW      = 64;
    localparam int DIV_DW      = 32;
    localparam int DIV_CW      = 6;
    localparam int RES_W       = 32;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_QUERY = 2'd2
    } req_e;

    typedef enum logic [1:0] {
        MODE_ST  = 2'd0,
        MODE_UV  = 2'd1,
        MODE_PIX = 2'd2
    } mode_e;

    typedef enum logic [1:0] {
        CFG_NBR  = 2'd0,
        CFG_MODE = 2'd1,
        CFG_FW   = 2'd2,
        CFG_FH   = 2'd3
    } cfg_e;

    typedef enum logic [1:0] {
        SEL_NU = 2'd0,
        SEL_NV = 2'd1,
        SEL_SU = 2'd2,
        SEL_SV = 2'd3
    } div_sel_e;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN,
        ST_WREAD,
        ST_RATIO,
        ST_MUL,
        ST_ACC,
        ST_DSTART,
        ST_DWAIT,
        ST_RESULT
    } state_e;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [COORD_W-1:0] coord_a;
        logic signed [COORD_W-1:0] coord_b;
        logic signed [COORD_W-1:0] coord_c;
        logic [15:0]               pixel_x;
        logic [15:0]               pixel_y;
        logic                      mask_pass;
    } in_t;

    typedef struct packed {
        logic signed [RES_W-1:0] u_out;
        logic signed [RES_W-1:0] v_out;
        logic [NB_CW-1:0]        neighbors_found;
        logic                    store_overflow;
    } out_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
        logic signed [COORD_W-1:0] c;
        logic [15:0]               px;
        logic [15:0]               py;
    } point_t;

    localparam int PT_W = $bits(point_t);

endpackage

@@ src/knn_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module knn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ src/knn_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on knn_pkg.
module knn_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [knn_pkg::DIV_NW-1:0]   num,
    input  logic [knn_pkg::DIV_DW-1:0]   den,
    output logic                         done,
    output logic [knn_pkg::DIV_NW-1:0]   quo
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [knn_pkg::DIV_CW-1:0]    cnt_reg;
    logic [knn_pkg::DIV_DW-1:0]    rem_reg;
    logic [knn_pkg::DIV_DW-1:0]    den_reg;
    logic [knn_pkg::DIV_NW-1:0]    q_reg;
    logic [knn_pkg::DIV_DW:0]      trial;
    logic                          ge;

    assign trial = {rem_reg, q_reg[knn_pkg::DIV_NW-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == {knn_pkg::DIV_CW{1'b1}})
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            q_reg   <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? knn_pkg::DIV_DW'(trial - {1'b0, den_reg})
                          : trial[knn_pkg::DIV_DW-1:0];
            q_reg   <= {q_reg[knn_pkg::DIV_NW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

@@ src/knn_srch.sv @@
`timescale 1ns / 1ps
// Distance pipeline and sorted k-best list for the exhaustive search.
// Depends on knn_pkg.
module knn_srch (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              clear,
    input  logic                              rd_valid,
    input  logic [knn_pkg::PT_AW-1:0]         rd_idx,
    input  knn_pkg::point_t                   rd_pt,
    input  logic signed [knn_pkg::COORD_W-1:0] qa,
    input  logic signed [knn_pkg::COORD_W-1:0] qb,
    input  logic signed [knn_pkg::COORD_W-1:0] qc,
    input  logic [knn_pkg::NB_CW-1:0]         k,
    output logic                              busy,
    output logic [knn_pkg::NB_CW-1:0]         found,
    output logic [knn_pkg::DIST_W-1:0]        best_dist [knn_pkg::MAX_NB],
    output logic [knn_pkg::PT_AW-1:0]         best_idx [knn_pkg::MAX_NB]
);

    logic                          v1_reg, v2_reg;
    logic [knn_pkg::PT_AW-1:0]     idx1_reg, idx2_reg;
    logic [knn_pkg::SQ_W-1:0]      sqa_reg, sqb_reg, sqc_reg;
    logic [knn_pkg::DIST_W-1:0]    d2_reg;
    logic [knn_pkg::MAG_W-1:0]     mag_a, mag_b, mag_c;
    logic [knn_pkg::NB_CW-1:0]     found_reg;
    logic [knn_pkg::DIST_W-1:0]    bd_reg [knn_pkg::MAX_NB];
    logic [knn_pkg::PT_AW-1:0]     bi_reg [knn_pkg::MAX_NB];
    logic [knn_pkg::MAX_NB-1:0]    gt;

    function automatic logic [knn_pkg::MAG_W-1:0] abs_diff(
        input logic signed [knn_pkg::COORD_W-1:0] x,
        input logic signed [knn_pkg::COORD_W-1:0] y
    );
        logic signed [knn_pkg::COORD_W:0] d;
        logic signed [knn_pkg::COORD_W:0] m;
        d = {x[knn_pkg::COORD_W-1], x} - {y[knn_pkg::COORD_W-1], y};
        m = d[knn_pkg::COORD_W] ? -d : d;
        return m[knn_pkg::MAG_W-1:0];
    endfunction

    function automatic logic [knn_pkg::NB_CW-1:0] NB_CW_J(input int j);
        return knn_pkg::NB_CW'(j);
    endfunction

    assign mag_a = abs_diff(rd_pt.a, qa);
    assign mag_b = abs_diff(rd_pt.b, qb);
    assign mag_c = abs_diff(rd_pt.c, qc);

    // Empty lanes count as farther than anything.
    always_comb
    begin
        for (int j = 0; j < knn_pkg::MAX_NB; j++)
        begin
            gt[j] = (NB_CW_J(j) >= found_reg) || (bd_reg[j] > d2_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            found_reg <= '0;
        end
        else
        begin
            v1_reg <= rd_valid;
            v2_reg <= v1_reg;
            if (clear)
            begin
                found_reg <= '0;
            end
            else if (v2_reg && found_reg < k)
            begin
                found_reg <= found_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= rd_idx;
        sqa_reg  <= mag_a * mag_a;
        sqb_reg  <= mag_b * mag_b;
        sqc_reg  <= mag_c * mag_c;
        idx2_reg <= idx1_reg;
        d2_reg   <= knn_pkg::DIST_W'(sqa_reg) + knn_pkg::DIST_W'(sqb_reg)
                    + knn_pkg::DIST_W'(sqc_reg);
        if (v2_reg)
        begin
            // Shift the farther entries down one lane and drop the new one in.
            for (int j = 0; j < knn_pkg::MAX_NB; j++)
            begin
                if (gt[j])
                begin
                    if (j == 0)
                    begin
                        bd_reg[j] <= d2_reg;
                        bi_reg[j] <= idx2_reg;
                    end
                    else if (!gt[j-1])
                    begin
                        bd_reg[j] <= d2_reg;
                        bi_reg[j] <= idx2_reg;
                    end
                    else
                    begin
                        bd_reg[j] <= bd_reg[j-1];
                        bi_reg[j] <= bi_reg[j-1];
                    end
                end
            end
        end
    end

    assign busy      = v1_reg | v2_reg;
    assign found     = found_reg;
    assign best_dist = bd_reg;
    assign best_idx  = bi_reg;

endmodule

@@ src/knn_idw_position_lookup_core.sv @@
`timescale 1ns / 1ps
// Top level of the k-nearest-neighbor inverse-distance position lookup.
// Depends on knn_pkg, knn_ram, knn_srch and knn_div.

// Clear and load transactions are taken in the idle state; a load writes the point
// memory at the next free entry. A query scans every stored point, one memory
// read per cycle, then works out the weight for each neighbor (one bit per cycle),
// then runs the divides: two divides for the average, and two more in st map mode,
// and then loads the output register once that register is free.
// Masked queries or queries on an empty store skip the search and the weighting.
// The single point memory port sets the scan rate, and the serial divider the divides.
// One transaction is worked at a time; a finished result waits in the output
// register while the next transaction is accepted.
module knn_idw_position_lookup_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  knn_pkg::in_t      in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output knn_pkg::out_t     out_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    knn_pkg::state_e               state_reg, state_next;

    logic [knn_pkg::NB_CW-1:0]     nbr_reg;
    logic [1:0]                    mode_reg;
    logic [15:0]                   fw_reg, fh_reg;
    logic [knn_pkg::CNT_W-1:0]     count_reg;
    logic                          ovf_reg;
    knn_pkg::in_t                  q_reg;
    logic [knn_pkg::NB_CW-1:0]     k_reg;
    logic [knn_pkg::CNT_W-1:0]     scan_reg;
    logic                          rd_valid_reg;
    logic [knn_pkg::PT_AW-1:0]     rd_idx_reg;
    logic [knn_pkg::NB_CW-1:0]     wi_reg;
    logic [knn_pkg::NB_CW-1:0]     step_reg;
    logic [knn_pkg::REM_W-1:0]     rem_reg;
    logic [knn_pkg::W_W-1:0]       w_reg;
    logic [knn_pkg::PROD_W-1:0]    pu_prod_reg, pv_prod_reg;
    logic [knn_pkg::SW_W-1:0]      sw_reg;
    logic [knn_pkg::ACC_W-1:0]     nu_reg, nv_reg;
    logic [knn_pkg::RES_W-1:0]     pu_reg, pv_reg, su_reg, sv_reg;
    logic [1:0]                    sel_reg;
    logic                          out_valid_reg;
    knn_pkg::out_t                 out_reg;

    logic                          accept;
    logic                          is_load, is_query, is_clear;
    logic                          load_ok;
    logic                          ram_we;
    logic [knn_pkg::PT_AW-1:0]     ram_addr;
    knn_pkg::point_t               ram_wdata, ram_rdata;
    logic                          srch_busy;
    logic [knn_pkg::NB_CW-1:0]     found;
    logic [knn_pkg::DIST_W-1:0]    best_dist [knn_pkg::MAX_NB];
    logic [knn_pkg::PT_AW-1:0]     best_idx [knn_pkg::MAX_NB];
    logic                          div_start, div_done;
    logic [knn_pkg::DIV_NW-1:0]    div_num, div_quo;
    logic [knn_pkg::DIV_DW-1:0]    div_den;
    logic [15:0]                   fw_eff, fh_eff;
    logic [knn_pkg::DIST_W-1:0]    dmin, di;
    logic [knn_pkg::REM_W-1:0]     shifted;
    logic                          ratio_ge;
    logic                          scan_last, ratio_last, wi_last, out_free;
    logic                          skip_search;
    logic [knn_pkg::RES_W-1:0]     u_val, v_val;

    assign accept    = in_valid && in_ready;
    assign is_clear  = in_data.req_type == knn_pkg::REQ_CLEAR;
    assign is_load   = in_data.req_type == knn_pkg::REQ_LOAD;
    assign is_query  = in_data.req_type == knn_pkg::REQ_QUERY;
    assign load_ok   = in_data.mask_pass && ((in_data.coord_a != '0)
                       || (in_data.coord_b != '0) || (in_data.coord_c != '0));
    assign skip_search = !in_data.mask_pass || (count_reg == '0);
    assign scan_last = scan_reg == count_reg - 1'b1;
    assign ratio_last = step_reg == knn_pkg::NB_CW'(knn_pkg::WEIGHT_BITS);
    assign wi_last   = wi_reg + 1'b1 == found;
    assign out_free  = !out_valid_reg || out_ready;
    assign fw_eff    = (fw_reg == '0) ? 16'd1 : fw_reg;
    assign fh_eff    = (fh_reg == '0) ? 16'd1 : fh_reg;

    assign dmin = (best_dist[0] < knn_pkg::EPS_DIST) ? knn_pkg::EPS_DIST : best_dist[0];
    assign di   = (best_dist[wi_reg[knn_pkg::NB_AW-1:0]] < knn_pkg::EPS_DIST)
                  ? knn_pkg::EPS_DIST : best_dist[wi_reg[knn_pkg::NB_AW-1:0]];
    assign shifted  = (step_reg == '0) ? rem_reg : {rem_reg[knn_pkg::REM_W-2:0], 1'b0};
    assign ratio_ge = shifted >= knn_pkg::REM_W'(di);

    assign ram_wdata = '{a: in_data.coord_a, b: in_data.coord_b, c: in_data.coord_c,
                         px: in_data.pixel_x, py: in_data.pixel_y};

    always_comb
    begin
        case (sel_reg)
            knn_pkg::SEL_NU:
            begin
                div_num = (knn_pkg::DIV_NW'(nu_reg) << 13) + knn_pkg::DIV_NW'(sw_reg >> 1);
                div_den = knn_pkg::DIV_DW'(sw_reg);
            end
            knn_pkg::SEL_NV:
            begin
                div_num = (knn_pkg::DIV_NW'(nv_reg) << 13) + knn_pkg::DIV_NW'(sw_reg >> 1);
                div_den = knn_pkg::DIV_DW'(sw_reg);
            end
            knn_pkg::SEL_SU:
            begin
                div_num = knn_pkg::DIV_NW'(pu_reg) + knn_pkg::DIV_NW'(fw_eff >> 1);
                div_den = knn_pkg::DIV_DW'(fw_eff);
            end
            default:
            begin
                div_num = knn_pkg::DIV_NW'(pv_reg) + knn_pkg::DIV_NW'(fh_eff >> 1);
                div_den = knn_pkg::DIV_DW'(fh_eff);
            end
        endcase
    end

    always_comb
    begin
        case (mode_reg)
            knn_pkg::MODE_ST:
            begin
                u_val = su_reg;
                v_val = sv_reg;
            end
            knn_pkg::MODE_UV:
            begin
                u_val = pu_reg - {2'b00, q_reg.pixel_x, 14'b0};
                v_val = pv_reg - {2'b00, q_reg.pixel_y, 14'b0};
            end
            default:
            begin
                u_val = pu_reg;
                v_val = pv_reg;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            knn_pkg::ST_IDLE:
            begin
                if (accept && is_query)
                begin
                    if (!skip_search)
                    begin
                        state_next = knn_pkg::ST_SEARCH;
                    end
                    else if (mode_reg == knn_pkg::MODE_ST)
                    begin
                        state_next = knn_pkg::ST_DSTART;
                    end
                    else
                    begin
                        state_next = knn_pkg::ST_RESULT;
                    end
                end
            end
            knn_pkg::ST_SEARCH:
            begin
                if (scan_last)
                begin
                    state_next = knn_pkg::ST_DRAIN;
                end
            end
            knn_pkg::ST_DRAIN:
            begin
                if (!rd_valid_reg && !srch_busy)
                begin
                    state_next = knn_pkg::ST_WREAD;
                end
            end
            knn_pkg::ST_WREAD:  state_next = knn_pkg::ST_RATIO;
            knn_pkg::ST_RATIO:
            begin
                if (ratio_last)
                begin
                    state_next = knn_pkg::ST_MUL;
                end
            end
            knn_pkg::ST_MUL:    state_next = knn_pkg::ST_ACC;
            knn_pkg::ST_ACC:
            begin
                state_next = wi_last ? knn_pkg::ST_DSTART : knn_pkg::ST_WREAD;
            end
            knn_pkg::ST_DSTART: state_next = knn_pkg::ST_DWAIT;
            knn_pkg::ST_DWAIT:
            begin
                if (div_done)
                begin
                    if (sel_reg == knn_pkg::SEL_SV)
                    begin
                        state_next = knn_pkg::ST_RESULT;
                    end
                    else if (sel_reg == knn_pkg::SEL_NV && mode_reg != knn_pkg::MODE_ST)
                    begin
                        state_next = knn_pkg::ST_RESULT;
                    end
                    else
                    begin
                        state_next = knn_pkg::ST_DSTART;
                    end
                end
            end
            knn_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = knn_pkg::ST_IDLE;
                end
            end
            default:            state_next = knn_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        div_start = 1'b0;
        ram_addr  = best_idx[wi_reg[knn_pkg::NB_AW-1:0]];
        case (state_reg)
            knn_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                ram_addr = count_reg[knn_pkg::PT_AW-1:0];
                ram_we   = accept && is_load && load_ok
                           && (count_reg < knn_pkg::CNT_W'(knn_pkg::MAX_POINTS));
            end
            knn_pkg::ST_SEARCH: ram_addr = scan_reg[knn_pkg::PT_AW-1:0];
            knn_pkg::ST_DSTART: div_start = 1'b1;
            default:            ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= knn_pkg::ST_IDLE;
            nbr_reg       <= 5'd3;
            mode_reg      <= knn_pkg::MODE_ST;
            fw_reg        <= 16'd1920;
            fh_reg        <= 16'd1080;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= state_reg == knn_pkg::ST_SEARCH;
            if (cfg_we)
            begin
                case (cfg_index)
                    knn_pkg::CFG_NBR:  nbr_reg  <= cfg_data[knn_pkg::NB_CW-1:0];
                    knn_pkg::CFG_MODE: mode_reg <= cfg_data[1:0];
                    knn_pkg::CFG_FW:   fw_reg   <= cfg_data;
                    default:           fh_reg   <= cfg_data;
                endcase
            end
            if (accept && is_clear)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (ram_we)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (accept && is_load && load_ok)
            begin
                ovf_reg <= 1'b1;
            end
            if (state_reg == knn_pkg::ST_RESULT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_reg[knn_pkg::PT_AW-1:0];
        case (state_reg)
            knn_pkg::ST_IDLE:
            begin
                q_reg    <= in_data;
                scan_reg <= '0;
                wi_reg   <= '0;
                sw_reg   <= '0;
                nu_reg   <= '0;
                nv_reg   <= '0;
                pu_reg   <= '0;
                pv_reg   <= '0;
                sel_reg  <= skip_search ? knn_pkg::SEL_SU : knn_pkg::SEL_NU;
                if (nbr_reg == '0)
                begin
                    k_reg <= knn_pkg::NB_CW'(1);
                end
                else if (nbr_reg > knn_pkg::NB_CW'(knn_pkg::MAX_NB))
                begin
                    k_reg <= knn_pkg::NB_CW'(knn_pkg::MAX_NB);
                end
                else
                begin
                    k_reg <= nbr_reg;
                end
            end
            knn_pkg::ST_SEARCH: scan_reg <= scan_reg + 1'b1;
            knn_pkg::ST_WREAD:
            begin
                rem_reg  <= knn_pkg::REM_W'(dmin);
                w_reg    <= '0;
                step_reg <= '0;
            end
            knn_pkg::ST_RATIO:
            begin
                rem_reg  <= ratio_ge ? shifted - knn_pkg::REM_W'(di) : shifted;
                w_reg    <= {w_reg[knn_pkg::W_W-2:0], ratio_ge};
                step_reg <= step_reg + 1'b1;
            end
            knn_pkg::ST_MUL:
            begin
                pu_prod_reg <= w_reg * {ram_rdata.px, 1'b1};
                pv_prod_reg <= w_reg * {ram_rdata.py, 1'b1};
            end
            knn_pkg::ST_ACC:
            begin
                sw_reg <= sw_reg + knn_pkg::SW_W'(w_reg);
                nu_reg <= nu_reg + knn_pkg::ACC_W'(pu_prod_reg);
                nv_reg <= nv_reg + knn_pkg::ACC_W'(pv_prod_reg);
                wi_reg <= wi_reg + 1'b1;
            end
            knn_pkg::ST_DWAIT:
            begin
                if (div_done)
                begin
                    case (sel_reg)
                        knn_pkg::SEL_NU: pu_reg <= div_quo[knn_pkg::RES_W-1:0];
                        knn_pkg::SEL_NV: pv_reg <= div_quo[knn_pkg::RES_W-1:0];
                        knn_pkg::SEL_SU: su_reg <= div_quo[knn_pkg::RES_W-1:0];
                        default:         sv_reg <= div_quo[knn_pkg::RES_W-1:0];
                    endcase
                    sel_reg <= sel_reg + 1'b1;
                end
            end
            knn_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    out_reg <= '{u_out: u_val, v_out: v_val, neighbors_found: found,
                                 store_overflow: ovf_reg};
                end
            end
            default:
            begin
                wi_reg <= wi_reg;
            end
        endcase
    end

    knn_ram #(
        .WIDTH (knn_pkg::PT_W),
        .DEPTH (knn_pkg::MAX_POINTS)
    ) u_points (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    knn_srch u_srch (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (accept && is_query),
        .rd_valid  (rd_valid_reg),
        .rd_idx    (rd_idx_reg),
        .rd_pt     (ram_rdata),
        .qa        (q_reg.coord_a),
        .qb        (q_reg.coord_b),
        .qc        (q_reg.coord_c),
        .k         (k_reg),
        .busy      (srch_busy),
        .found     (found),
        .best_dist (best_dist),
        .best_idx  (best_idx)
    );

    knn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= knn_pkg::CNT_W'(knn_pkg::MAX_POINTS))
        else $error("point count above capacity");

    a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != knn_pkg::ST_IDLE |-> found <= k_reg)
        else $error("neighbor list longer than k");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == knn_pkg::ST_IDLE)
        else $error("point memory written during a query");

    a_ratio_found: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == knn_pkg::ST_WREAD |-> wi_reg < found)
        else $error("weight pass past the neighbor list");

endmodule
